FILE: hdl/lpht_pkg.sv
package lpht_pkg;

  // table geometry, slot index is the low key bits (size is a power of two)
  localparam int TABLE_SIZE = 4096;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 22;
  localparam int VAL_W      = 12;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SIZE - 1);

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  typedef logic [SLOT_W-1:0] slot_idx_t;

  // one table entry
  typedef struct packed {
    logic             used;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

  // write request into the slot memory
  typedef struct packed {
    logic      we;
    slot_idx_t addr;
    slot_t     data;
  } mem_wr_t;

  // finished result handed to the output register
  typedef struct packed {
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  value;
  } res_t;

endpackage

FILE: hdl/lpht_slot_mem.sv
module lpht_slot_mem
  import lpht_pkg::*;
(
  input  logic      clk,
  input  slot_idx_t rd_addr,
  output slot_t     rd_data,
  input  mem_wr_t   wr
);

  slot_t mem [TABLE_SIZE];
  slot_t rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hdl/lpht_ctrl.sv
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   in_op,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [VAL_W-1:0]  in_val,
  output slot_idx_t         rd_addr,
  input  slot_t             rd_data,
  output mem_wr_t           wr,
  output res_t              res,
  input  logic              out_free
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  slot_idx_t         ptr_r, ptr_nxt;
  slot_idx_t         cnt_r, cnt_nxt;
  logic              clr_op_r, clr_op_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [VAL_W-1:0]  found_r, found_nxt;
  slot_idx_t         ptr_inc;
  slot_idx_t         home;
  logic              in_beat;
  logic              probe_more;

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign home     = in_key[SLOT_W-1:0];
  assign ptr_inc  = (ptr_r == SLOT_LAST) ? '0 : ptr_r + 1'b1;

  assign res.valid  = (state_r == ST_RESP);
  assign res.status = status_r;
  assign res.value  = found_r;

  // sequencer: one slot probed per cycle; only a find compares keys, an insert takes the first unused slot
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    val_nxt    = val_r;
    ptr_nxt    = ptr_r;
    cnt_nxt    = cnt_r;
    clr_op_nxt = clr_op_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    rd_addr    = ptr_r;
    wr         = '0;
    probe_more = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          op_nxt     = in_op;
          key_nxt    = in_key;
          val_nxt    = in_val;
          status_nxt = STAT_OK;
          found_nxt  = '0;
          case (in_op)
            OP_INSERT, OP_FIND: begin
              rd_addr   = home;
              ptr_nxt   = home;
              cnt_nxt   = '0;
              state_nxt = ST_PROBE;
            end
            OP_CLEAR: begin
              ptr_nxt    = '0;
              clr_op_nxt = 1'b1;
              state_nxt  = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_PROBE: begin
        rd_addr = ptr_inc;
        if (op_r == OP_INSERT) begin
          if (!rd_data.used) begin
            wr.we      = 1'b1;
            wr.addr    = ptr_r;
            wr.data    = '{used: 1'b1, key: key_r, value: val_r};
            status_nxt = STAT_OK;
            state_nxt  = ST_RESP;
          end else if (cnt_r == SLOT_LAST) begin
            status_nxt = STAT_FULL;
            state_nxt  = ST_RESP;
          end else begin
            probe_more = 1'b1;
          end
        end else begin
          if (!rd_data.used) begin
            status_nxt = STAT_MISS;
            state_nxt  = ST_RESP;
          end else if (rd_data.key == key_r) begin
            status_nxt = STAT_OK;
            found_nxt  = rd_data.value;
            state_nxt  = ST_RESP;
          end else if (cnt_r == SLOT_LAST) begin
            status_nxt = STAT_MISS;
            state_nxt  = ST_RESP;
          end else begin
            probe_more = 1'b1;
          end
        end
        if (probe_more) begin
          ptr_nxt = ptr_inc;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_CLEAR: begin
        wr.we   = 1'b1;
        wr.addr = ptr_r;
        wr.data = '0;
        if (ptr_r == SLOT_LAST) begin
          clr_op_nxt = 1'b0;
          state_nxt  = clr_op_r ? ST_RESP : ST_IDLE;
        end else begin
          ptr_nxt = ptr_inc;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      ptr_r    <= '0;
      clr_op_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      clr_op_r <= clr_op_nxt;
    end
  end

  // operand and result holding registers
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    val_r    <= val_nxt;
    cnt_r    <= cnt_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
  end

  // a new beat is never taken in the cycle after one was accepted
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_ready)
    else $error("beat accepted twice in a row");

  // an insert only writes a slot it found unused
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE && wr.we) |-> !rd_data.used)
    else $error("insert overwrote a used slot");

  // table full is only reported for an insert
  a_full_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.status == STAT_FULL) |-> op_r == OP_INSERT)
    else $error("full status on non-insert");

  // a nonzero value only comes from a find hit
  a_value_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.value != '0) |-> (op_r == OP_FIND && res.status == STAT_OK))
    else $error("value returned without a hit");

  // the clear sweep writes each cycle
  a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (wr.we && wr.addr == ptr_r && !wr.data.used))
    else $error("clear sweep missed a slot");

endmodule

FILE: hdl/linear_probe_hash_table.sv
// channel  dir  ports                         payload
// in       in   in_tvalid/in_tready/in_tdata  tdata: key, value; tuser: opcode
// out      out  out_tvalid/out_tready/out_tdata  tdata: found_value; tuser: status
//
// insert/find: accepted in IDLE, slots probed in PROBE, result held in RESP until
//   handed off; the registered slot memory read sets the one-slot-per-cycle pace
// clear: a sweep writes every slot to zero, then the result
// reset: a sweep over every slot clears the used bits; in_tready stays low meanwhile
// one item at a time; a held result in the output register does not block the
//   next beat, only the hand-off of its result
module linear_probe_hash_table
  import lpht_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // key[21:0], value[33:22], zero pad
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // found_value[11:0], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  slot_idx_t         rd_addr;
  slot_t             rd_data;
  mem_wr_t           wr;
  res_t              res;
  logic              out_free;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [VAL_W-1:0]  out_value_r;

  assign out_free = !out_valid_r || out_tready;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser[OP_W-1:0]),
    .in_key   (in_tdata[KEY_W-1:0]),
    .in_val   (in_tdata[KEY_W+VAL_W-1:KEY_W]),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr       (wr),
    .res      (res),
    .out_free (out_free)
  );

  lpht_slot_mem u_mem (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res.valid;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      out_status_r <= res.status;
      out_value_r  <= res.value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_value_r};
  assign out_tuser  = out_status_r;

endmodule
